// ----- rtl/core/ccrc_pkg.sv -----
// Shared types and constants for the coin classifier and roll counter.
package ccrc_pkg;

   localparam int unsigned NUM_ROLLS = 5;

   typedef enum logic [2:0] {
      DEST_NICKEL  = 3'd0,
      DEST_DIME    = 3'd1,
      DEST_QUARTER = 3'd2,
      DEST_LOONIE  = 3'd3,
      DEST_TWONIE  = 3'd4,
      DEST_OTHER   = 3'd5,
      DEST_BENT    = 3'd6
   } dest_type;

   typedef enum logic [2:0] {
      CSR_NICKEL_CAP  = 3'd0,
      CSR_DIME_CAP    = 3'd1,
      CSR_QUARTER_CAP = 3'd2,
      CSR_LOONIE_CAP  = 3'd3,
      CSR_TWONIE_CAP  = 3'd4,
      CSR_BENT_LIMIT  = 3'd5,
      CSR_OTHER_LIMIT = 3'd6
   } csr_index_type;

   localparam logic [5:0]  CAP_RESET [NUM_ROLLS] = '{6'd40, 6'd50, 6'd40, 6'd25, 6'd25};
   localparam logic [12:0] BENT_LIMIT_RESET  = 13'd2550;
   localparam logic [12:0] OTHER_LIMIT_RESET = 13'd5100;

   typedef struct packed {
      logic [2:0]  destination;
      logic        container_replaced;
      logic [15:0] fill_count;
      logic [12:0] container_weight;
      logic [15:0] full_units_made;
      logic [31:0] total_weight;
      logic [31:0] other_total_count;
   } rsp_type;

endpackage

// ----- rtl/core/coin_classifier_roll_counter.sv -----
// An accepted beat is held in the input register and then loaded into the result register.
// Throughput: one coin per cycle; the input register and the result register
// stall only when the result register is full and rsp_stall is high.
// Reset clears all counters, container weights and totals, loads the default
// roll capacities and container limits, and empties both registers.
module coin_classifier_roll_counter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_weight_code,
   input  logic [7:0]  req_diameter_code,
   input  logic        req_is_bent,
   input  logic [1:0]  req_image_match,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_destination,
   output logic        rsp_container_replaced,
   output logic [15:0] rsp_fill_count,
   output logic [12:0] rsp_container_weight,
   output logic [15:0] rsp_full_units_made,
   output logic [31:0] rsp_total_weight,
   output logic [31:0] rsp_other_total_count,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [12:0] csr_wdata
);

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  weight_ff;
   logic [7:0]  diameter_ff;
   logic        bent_ff;
   logic [1:0]  image_ff;
   logic        out_valid_ff, out_valid_in;
   ccrc_pkg::rsp_type  out_ff;
   ccrc_pkg::rsp_type  rsp_next;
   ccrc_pkg::dest_type dest;
   logic        accept;
   logic        advance;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && out_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   ccrc_classify u_classify (
      .weight_code   (weight_ff),
      .diameter_code (diameter_ff),
      .is_bent       (bent_ff),
      .image_match   (image_ff),
      .dest          (dest)
   );

   ccrc_state u_state (
      .clock       (clock),
      .reset       (reset),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .advance     (advance),
      .weight_code (weight_ff),
      .dest        (dest),
      .rsp         (rsp_next)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         weight_ff   <= req_weight_code;
         diameter_ff <= req_diameter_code;
         bent_ff     <= req_is_bent;
         image_ff    <= req_image_match;
      end
      if (advance) begin
         out_ff <= rsp_next;
      end
   end

   assign rsp_valid              = out_valid_ff;
   assign rsp_destination        = out_ff.destination;
   assign rsp_container_replaced = out_ff.container_replaced;
   assign rsp_fill_count         = out_ff.fill_count;
   assign rsp_container_weight   = out_ff.container_weight;
   assign rsp_full_units_made    = out_ff.full_units_made;
   assign rsp_total_weight       = out_ff.total_weight;
   assign rsp_other_total_count  = out_ff.other_total_count;

   a_accept_loads : assert property (@(posedge clock) disable iff (reset)
      accept |=> in_valid_ff)
      else $error("accepted beat not held in input register");

   a_full_stalls : assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && rsp_stall) |=> (in_valid_ff && out_valid_ff))
      else $error("beat lost while result register stalled");

   a_bent_no_count : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_destination == ccrc_pkg::DEST_BENT) |->
      (rsp_fill_count == 16'd0 && rsp_full_units_made == 16'd0))
      else $error("bent result carries roll counts");

   a_roll_no_weight : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_destination <= ccrc_pkg::DEST_TWONIE) |->
      (rsp_container_weight == 13'd0 && rsp_total_weight == 32'd0))
      else $error("roll result carries container weight");

   a_roll_replace_empty : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_container_replaced && rsp_destination != ccrc_pkg::DEST_BENT) |->
      (rsp_fill_count == 16'd0))
      else $error("replaced roll or container not empty");

endmodule

// ----- rtl/core/ccrc_classify.sv -----
// Weight and diameter window match, with bent and image checks, that picks a coin's destination.
module ccrc_classify (
   input  logic [7:0]          weight_code,
   input  logic [7:0]          diameter_code,
   input  logic                is_bent,
   input  logic [1:0]          image_match,
   output ccrc_pkg::dest_type  dest
);

   // weight bounds in hundredths of a gram, diameter bounds in tenths of a mm
   localparam int unsigned W_LO [ccrc_pkg::NUM_ROLLS] = '{360, 130, 400, 650, 675};
   localparam int unsigned W_HI [ccrc_pkg::NUM_ROLLS] = '{430, 220, 480, 750, 785};
   localparam int unsigned D_LO [ccrc_pkg::NUM_ROLLS] = '{202, 173, 228, 250, 269};
   localparam int unsigned D_HI [ccrc_pkg::NUM_ROLLS] = '{218, 187, 246, 270, 291};

   logic [17:0] wv;
   logic [17:0] dv;
   logic [ccrc_pkg::NUM_ROLLS-1:0] hit;

   assign wv = 18'(weight_code) * 18'd1000;
   assign dv = 18'(diameter_code) * 18'd300;

   always_comb begin
      for (int k = 0; k < ccrc_pkg::NUM_ROLLS; k++) begin
         hit[k] = (wv >= 18'(W_LO[k] * 255)) && (wv <= 18'(W_HI[k] * 255)) &&
                  (dv >= 18'((D_LO[k] - 100) * 255)) && (dv <= 18'((D_HI[k] - 100) * 255));
      end
   end

   always_comb begin
      dest = ccrc_pkg::DEST_OTHER;
      if (is_bent) begin
         dest = ccrc_pkg::DEST_BENT;
      end else if (image_match == 2'd0) begin
         // walk down so the lowest matching window wins
         for (int k = ccrc_pkg::NUM_ROLLS - 1; k >= 0; k--) begin
            if (hit[k]) begin
               dest = ccrc_pkg::dest_type'(3'(k));
            end
         end
      end
   end

endmodule

// ----- rtl/core/ccrc_state.sv -----
// Roll counters, container weights, totals and configuration registers.
module ccrc_state (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [12:0]        csr_wdata,
   input  logic               advance,
   input  logic [7:0]         weight_code,
   input  ccrc_pkg::dest_type dest,
   output ccrc_pkg::rsp_type  rsp
);

   localparam int unsigned NR = ccrc_pkg::NUM_ROLLS;

   logic [5:0]  cap_ff [NR];
   logic [12:0] bent_limit_ff;
   logic [12:0] other_limit_ff;

   logic [5:0]  roll_cnt_ff [NR];
   logic [5:0]  roll_cnt_in [NR];
   logic [15:0] rolls_done_ff [NR];
   logic [15:0] rolls_done_in [NR];
   logic [12:0] bent_raw_ff, bent_raw_in;
   logic [12:0] other_raw_ff, other_raw_in;
   logic [15:0] other_coins_ff, other_coins_in;
   logic [15:0] other_filled_ff, other_filled_in;
   logic [31:0] other_total_ff, other_total_in;
   logic [31:0] bent_wt_ff, bent_wt_in;
   logic [31:0] other_wt_ff, other_wt_in;

   logic [2:0]  idx;
   logic [6:0]  cnt_next;
   logic        roll_full;
   logic [13:0] bent_sum;
   logic        bent_full;
   logic [13:0] other_sum;
   logic        other_full;
   logic [15:0] other_coins_inc;

   function automatic logic [15:0] sat16_inc(input logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   function automatic logic [31:0] sat32_add(input logic [31:0] v, input logic [7:0] a);
      logic [32:0] s;
      s = {1'b0, v} + 33'(a);
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   assign idx = (dest <= ccrc_pkg::DEST_TWONIE) ? 3'(dest) : 3'd0;

   always_comb begin
      roll_cnt_in     = roll_cnt_ff;
      rolls_done_in   = rolls_done_ff;
      bent_raw_in     = bent_raw_ff;
      other_raw_in    = other_raw_ff;
      other_coins_in  = other_coins_ff;
      other_filled_in = other_filled_ff;
      other_total_in  = other_total_ff;
      bent_wt_in      = bent_wt_ff;
      other_wt_in     = other_wt_ff;

      cnt_next  = 7'(roll_cnt_ff[idx]) + 7'd1;
      roll_full = cnt_next > 7'(cap_ff[idx]);

      // a container also turns over when the 13-bit sum would wrap
      bent_sum   = 14'(bent_raw_ff) + 14'(weight_code);
      bent_full  = (bent_sum > 14'(bent_limit_ff)) || bent_sum[13];
      other_sum  = 14'(other_raw_ff) + 14'(weight_code);
      other_full = (other_sum > 14'(other_limit_ff)) || other_sum[13];
      other_coins_inc = sat16_inc(other_coins_ff);

      rsp = '0;
      rsp.destination = 3'(dest);

      case (dest)
         ccrc_pkg::DEST_BENT: begin
            bent_wt_in  = sat32_add(bent_wt_ff, weight_code);
            bent_raw_in = bent_full ? 13'(weight_code) : bent_sum[12:0];
            rsp.container_replaced = bent_full;
            rsp.container_weight   = bent_raw_in;
            rsp.total_weight       = bent_wt_in;
         end
         ccrc_pkg::DEST_OTHER: begin
            other_total_in  = sat32_add(other_total_ff, 8'd1);
            other_wt_in     = sat32_add(other_wt_ff, weight_code);
            other_raw_in    = other_full ? 13'(weight_code) : other_sum[12:0];
            other_coins_in  = other_full ? 16'd0 : other_coins_inc;
            other_filled_in = other_full ? sat16_inc(other_filled_ff) : other_filled_ff;
            rsp.container_replaced = other_full;
            rsp.fill_count         = other_coins_in;
            rsp.container_weight   = other_raw_in;
            rsp.full_units_made    = other_filled_in;
            rsp.total_weight       = other_wt_in;
         end
         default: begin
            // drop the coin that overflows the roll
            roll_cnt_in[idx]   = roll_full ? 6'd0 : cnt_next[5:0];
            rolls_done_in[idx] = roll_full ? sat16_inc(rolls_done_ff[idx])
                                           : rolls_done_ff[idx];
            rsp.container_replaced = roll_full;
            rsp.fill_count         = 16'(roll_cnt_in[idx]);
            rsp.full_units_made    = rolls_done_in[idx];
         end
      endcase

      rsp.other_total_count = other_total_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff          <= ccrc_pkg::CAP_RESET;
         bent_limit_ff   <= ccrc_pkg::BENT_LIMIT_RESET;
         other_limit_ff  <= ccrc_pkg::OTHER_LIMIT_RESET;
         for (int k = 0; k < NR; k++) begin
            roll_cnt_ff[k]   <= '0;
            rolls_done_ff[k] <= '0;
         end
         bent_raw_ff     <= '0;
         other_raw_ff    <= '0;
         other_coins_ff  <= '0;
         other_filled_ff <= '0;
         other_total_ff  <= '0;
         bent_wt_ff      <= '0;
         other_wt_ff     <= '0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               ccrc_pkg::CSR_NICKEL_CAP:  cap_ff[0]      <= csr_wdata[5:0];
               ccrc_pkg::CSR_DIME_CAP:    cap_ff[1]      <= csr_wdata[5:0];
               ccrc_pkg::CSR_QUARTER_CAP: cap_ff[2]      <= csr_wdata[5:0];
               ccrc_pkg::CSR_LOONIE_CAP:  cap_ff[3]      <= csr_wdata[5:0];
               ccrc_pkg::CSR_TWONIE_CAP:  cap_ff[4]      <= csr_wdata[5:0];
               ccrc_pkg::CSR_BENT_LIMIT:  bent_limit_ff  <= csr_wdata;
               ccrc_pkg::CSR_OTHER_LIMIT: other_limit_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (advance) begin
            roll_cnt_ff     <= roll_cnt_in;
            rolls_done_ff   <= rolls_done_in;
            bent_raw_ff     <= bent_raw_in;
            other_raw_ff    <= other_raw_in;
            other_coins_ff  <= other_coins_in;
            other_filled_ff <= other_filled_in;
            other_total_ff  <= other_total_in;
            bent_wt_ff      <= bent_wt_in;
            other_wt_ff     <= other_wt_in;
         end
      end
   end

endmodule

// ----- verif/coin_classifier_roll_counter_tb.sv -----
// Self-checking testbench for the coin classifier and roll counter.
module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] IMG_BOTH   = 2'd0;
   localparam logic [1:0] IMG_ONE    = 2'd1;
   localparam logic [1:0] IMG_NONE   = 2'd2;
   localparam logic [1:0] IMG_UNUSED = 2'd3;

   localparam logic [12:0] CONTAINER_FULL = 13'd8191;

   // window bounds: weight in hundredths of a gram, diameter in tenths of a mm
   localparam int unsigned WIN_W_LO [ccrc_pkg::NUM_ROLLS] = '{360, 130, 400, 650, 675};
   localparam int unsigned WIN_W_HI [ccrc_pkg::NUM_ROLLS] = '{430, 220, 480, 750, 785};
   localparam int unsigned WIN_D_LO [ccrc_pkg::NUM_ROLLS] = '{202, 173, 228, 250, 269};
   localparam int unsigned WIN_D_HI [ccrc_pkg::NUM_ROLLS] = '{218, 187, 246, 270, 291};

   // the same windows as sensor codes, used only to aim random coins
   localparam int unsigned AIM_W_LO [ccrc_pkg::NUM_ROLLS] = '{92, 34, 102, 166, 173};
   localparam int unsigned AIM_W_HI [ccrc_pkg::NUM_ROLLS] = '{109, 56, 122, 191, 200};
   localparam int unsigned AIM_D_LO [ccrc_pkg::NUM_ROLLS] = '{87, 63, 109, 128, 144};
   localparam int unsigned AIM_D_HI [ccrc_pkg::NUM_ROLLS] = '{100, 73, 124, 144, 162};

   // per phase: coin count, capacity, limits (-1 picks at random), coin mix
   localparam int NUM_PHASES = 6;
   localparam int PH_ITEMS    [NUM_PHASES] = '{60, 120, 60, 70, 70, 70};
   localparam int PH_CAP      [NUM_PHASES] = '{0, 63, 1, -1, -1, -1};
   localparam int PH_BENT_LIM [NUM_PHASES] = '{0, 8191, 7936, -1, -1, -1};
   localparam int PH_OTHR_LIM [NUM_PHASES] = '{0, 8191, 7936, -1, -1, -1};
   localparam int PH_ROLL_PCT [NUM_PHASES] = '{60, 10, 60, 60, 60, 60};
   localparam int PH_BENT_PCT [NUM_PHASES] = '{15, 45, 15, 15, 15, 15};
   localparam int PH_HEAVY    [NUM_PHASES] = '{0, 1, 0, 0, 0, 0};

   typedef struct packed {
      logic [7:0] weight;
      logic [7:0] diameter;
      logic       bent;
      logic [1:0] image;
   } coin_reading_type;

   typedef struct packed {
      coin_reading_type  coin;
      logic              typed;
      ccrc_pkg::rsp_type result;
   } coin_row_type;

   localparam ccrc_pkg::rsp_type NO_RESULT = '0;

   // typed rows run from reset with the default capacities and limits
   localparam int NUM_ROWS = 24;
   localparam coin_row_type DIRECTED [NUM_ROWS] = '{
      '{'{8'd92, 8'd87, 1'b0, IMG_BOTH}, 1'b1,
        '{ccrc_pkg::DEST_NICKEL, 1'b0, 16'd1, 13'd0, 16'd0, 32'd0, 32'd0}},
      '{'{8'd109, 8'd100, 1'b0, IMG_BOTH}, 1'b1,
        '{ccrc_pkg::DEST_NICKEL, 1'b0, 16'd2, 13'd0, 16'd0, 32'd0, 32'd0}},
      '{'{8'd34, 8'd63, 1'b0, IMG_BOTH}, 1'b1,
        '{ccrc_pkg::DEST_DIME, 1'b0, 16'd1, 13'd0, 16'd0, 32'd0, 32'd0}},
      '{'{8'd56, 8'd73, 1'b0, IMG_BOTH}, 1'b1,
        '{ccrc_pkg::DEST_DIME, 1'b0, 16'd2, 13'd0, 16'd0, 32'd0, 32'd0}},
      '{'{8'd102, 8'd109, 1'b0, IMG_BOTH}, 1'b1,
        '{ccrc_pkg::DEST_QUARTER, 1'b0, 16'd1, 13'd0, 16'd0, 32'd0, 32'd0}},
      '{'{8'd122, 8'd124, 1'b0, IMG_BOTH}, 1'b1,
        '{ccrc_pkg::DEST_QUARTER, 1'b0, 16'd2, 13'd0, 16'd0, 32'd0, 32'd0}},
      '{'{8'd166, 8'd128, 1'b0, IMG_BOTH}, 1'b1,
        '{ccrc_pkg::DEST_LOONIE, 1'b0, 16'd1, 13'd0, 16'd0, 32'd0, 32'd0}},
      // fits both loonie and twonie windows; loonie is tested first
      '{'{8'd191, 8'd144, 1'b0, IMG_BOTH}, 1'b1,
        '{ccrc_pkg::DEST_LOONIE, 1'b0, 16'd2, 13'd0, 16'd0, 32'd0, 32'd0}},
      '{'{8'd200, 8'd162, 1'b0, IMG_BOTH}, 1'b1,
        '{ccrc_pkg::DEST_TWONIE, 1'b0, 16'd1, 13'd0, 16'd0, 32'd0, 32'd0}},
      '{'{8'd173, 8'd145, 1'b0, IMG_BOTH}, 1'b1,
        '{ccrc_pkg::DEST_TWONIE, 1'b0, 16'd2, 13'd0, 16'd0, 32'd0, 32'd0}},
      '{'{8'd110, 8'd87, 1'b0, IMG_BOTH}, 1'b1,
        '{ccrc_pkg::DEST_OTHER, 1'b0, 16'd1, 13'd110, 16'd0, 32'd110, 32'd1}},
      '{'{8'd92, 8'd87, 1'b0, IMG_ONE}, 1'b1,
        '{ccrc_pkg::DEST_OTHER, 1'b0, 16'd2, 13'd202, 16'd0, 32'd202, 32'd2}},
      '{'{8'd0, 8'd0, 1'b0, IMG_NONE}, 1'b1,
        '{ccrc_pkg::DEST_OTHER, 1'b0, 16'd3, 13'd202, 16'd0, 32'd202, 32'd3}},
      '{'{8'd92, 8'd87, 1'b0, IMG_UNUSED}, 1'b1,
        '{ccrc_pkg::DEST_OTHER, 1'b0, 16'd4, 13'd294, 16'd0, 32'd294, 32'd4}},
      '{'{8'd255, 8'd255, 1'b1, IMG_BOTH}, 1'b1,
        '{ccrc_pkg::DEST_BENT, 1'b0, 16'd0, 13'd255, 16'd0, 32'd255, 32'd4}},
      '{'{8'd0, 8'd0, 1'b1, IMG_UNUSED}, 1'b1,
        '{ccrc_pkg::DEST_BENT, 1'b0, 16'd0, 13'd255, 16'd0, 32'd255, 32'd4}},
      '{'{8'd255, 8'd255, 1'b0, IMG_BOTH}, 1'b1,
        '{ccrc_pkg::DEST_OTHER, 1'b0, 16'd5, 13'd549, 16'd0, 32'd549, 32'd5}},
      // one code outside a window edge
      '{'{8'd91, 8'd87, 1'b0, IMG_BOTH}, 1'b0, NO_RESULT},
      '{'{8'd92, 8'd86, 1'b0, IMG_BOTH}, 1'b0, NO_RESULT},
      '{'{8'd33, 8'd63, 1'b0, IMG_BOTH}, 1'b0, NO_RESULT},
      '{'{8'd57, 8'd73, 1'b0, IMG_BOTH}, 1'b0, NO_RESULT},
      '{'{8'd165, 8'd128, 1'b0, IMG_BOTH}, 1'b0, NO_RESULT},
      '{'{8'd201, 8'd162, 1'b0, IMG_BOTH}, 1'b0, NO_RESULT},
      '{'{8'd200, 8'd163, 1'b0, IMG_BOTH}, 1'b0, NO_RESULT}
   };

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   coin_reading_type req_coin;
   logic             rsp_valid;
   logic             rsp_stall;
   logic [2:0]       rsp_destination;
   logic             rsp_container_replaced;
   logic [15:0]      rsp_fill_count;
   logic [12:0]      rsp_container_weight;
   logic [15:0]      rsp_full_units_made;
   logic [31:0]      rsp_total_weight;
   logic [31:0]      rsp_other_total_count;
   logic             csr_write;
   logic [2:0]       csr_index;
   logic [12:0]      csr_wdata;

   // sorter model state and its copy of the registers
   logic [5:0]  roll_cap [ccrc_pkg::NUM_ROLLS];
   logic [12:0] bent_limit;
   logic [12:0] other_limit;
   logic [5:0]  roll_count [ccrc_pkg::NUM_ROLLS];
   logic [15:0] rolls_done [ccrc_pkg::NUM_ROLLS];
   logic [12:0] bent_raw;
   logic [12:0] other_raw;
   logic [15:0] other_coins;
   logic [15:0] other_bins_done;
   logic [31:0] other_coin_total;
   logic [31:0] bent_weight_sum;
   logic [31:0] other_weight_sum;

   ccrc_pkg::rsp_type coin_results_due [$];
   int unsigned mismatch_count = 0;
   int unsigned burst_left = 0;

   coin_classifier_roll_counter dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_weight_code        (req_coin.weight),
      .req_diameter_code      (req_coin.diameter),
      .req_is_bent            (req_coin.bent),
      .req_image_match        (req_coin.image),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_destination        (rsp_destination),
      .rsp_container_replaced (rsp_container_replaced),
      .rsp_fill_count         (rsp_fill_count),
      .rsp_container_weight   (rsp_container_weight),
      .rsp_full_units_made    (rsp_full_units_made),
      .rsp_total_weight       (rsp_total_weight),
      .rsp_other_total_count  (rsp_other_total_count),
      .csr_write              (csr_write),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #500_000;
      $display("testbench: FAIL");
      $finish;
   end

   function automatic logic [31:0] sat_add32(logic [31:0] a, logic [31:0] b);
      logic [32:0] sum;
      sum = {1'b0, a} + {1'b0, b};
      return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
   endfunction

   // returns {replaced, new contents}; a replaced container holds only this coin
   function automatic logic [13:0] fill_bin(logic [12:0] held, logic [7:0] w,
                                            logic [12:0] limit);
      logic [13:0] sum;
      sum = {1'b0, held} + {6'd0, w};
      if (sum > {1'b0, limit} || sum > {1'b0, CONTAINER_FULL}) begin
         return {1'b1, 5'd0, w};
      end
      return {1'b0, sum[12:0]};
   endfunction

   function automatic ccrc_pkg::rsp_type sort_coin(coin_reading_type c);
      ccrc_pkg::rsp_type r;
      logic        found;
      int unsigned roll;
      int unsigned wv;
      int unsigned dv;
      logic [6:0]  n;
      logic [13:0] bin;
      r = '0;
      r.destination = ccrc_pkg::DEST_OTHER;
      found = 1'b0;
      roll = 0;
      wv = 1000 * int'(c.weight);
      dv = 300 * int'(c.diameter);
      if (c.bent) begin
         r.destination = ccrc_pkg::DEST_BENT;
         bent_weight_sum = sat_add32(bent_weight_sum, {24'd0, c.weight});
         bin = fill_bin(bent_raw, c.weight, bent_limit);
         bent_raw = bin[12:0];
         r.container_replaced = bin[13];
         r.container_weight = bent_raw;
         r.total_weight = bent_weight_sum;
      end else begin
         if (c.image == IMG_BOTH) begin
            for (int k = 0; k < ccrc_pkg::NUM_ROLLS; k++) begin
               if (!found && wv >= WIN_W_LO[k] * 255 && wv <= WIN_W_HI[k] * 255 &&
                   dv >= (WIN_D_LO[k] - 100) * 255 && dv <= (WIN_D_HI[k] - 100) * 255) begin
                  found = 1'b1;
                  roll = k;
               end
            end
         end
         if (found) begin
            r.destination = 3'(roll);
            n = {1'b0, roll_count[roll]} + 7'd1;
            if (n > {1'b0, roll_cap[roll]}) begin
               n = '0;
               if (rolls_done[roll] != 16'hFFFF) rolls_done[roll] = rolls_done[roll] + 16'd1;
               r.container_replaced = 1'b1;
            end
            roll_count[roll] = n[5:0];
            r.fill_count = {10'd0, n[5:0]};
            r.full_units_made = rolls_done[roll];
         end else begin
            if (other_coins != 16'hFFFF) other_coins = other_coins + 16'd1;
            other_coin_total = sat_add32(other_coin_total, 32'd1);
            other_weight_sum = sat_add32(other_weight_sum, {24'd0, c.weight});
            bin = fill_bin(other_raw, c.weight, other_limit);
            other_raw = bin[12:0];
            if (bin[13]) begin
               other_coins = '0;
               if (other_bins_done != 16'hFFFF) other_bins_done = other_bins_done + 16'd1;
               r.container_replaced = 1'b1;
            end
            r.fill_count = other_coins;
            r.container_weight = other_raw;
            r.full_units_made = other_bins_done;
            r.total_weight = other_weight_sum;
         end
      end
      r.other_total_count = other_coin_total;
      return r;
   endfunction

   // roll_pct coins aimed at a window edge or inside it, then bent_pct bent coins, then noise
   function automatic coin_reading_type random_coin(int roll_pct, int bent_pct, int heavy);
      coin_reading_type c;
      int unsigned      pick;
      int unsigned      k;
      pick = $urandom_range(0, 99);
      c.bent = 1'b0;
      c.image = IMG_BOTH;
      if (pick < roll_pct) begin
         k = $urandom_range(0, ccrc_pkg::NUM_ROLLS - 1);
         c.weight = 8'($urandom_range(AIM_W_LO[k] - 2, AIM_W_HI[k] + 2));
         c.diameter = 8'($urandom_range(AIM_D_LO[k] - 2, AIM_D_HI[k] + 2));
      end else begin
         c.weight = heavy != 0 ? 8'($urandom_range(200, 255)) : 8'($urandom_range(0, 255));
         c.diameter = 8'($urandom_range(0, 255));
         c.image = 2'($urandom_range(0, 3));
         c.bent = pick < roll_pct + bent_pct;
      end
      return c;
   endfunction

   task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, field, got, want);
      mismatch_count++;
   endtask

   // present one coin, hold it until accepted, and log what it should produce
   task automatic send_coin(coin_reading_type c, logic typed,
                            ccrc_pkg::rsp_type typed_result);
      int unsigned       gap;
      ccrc_pkg::rsp_type predicted;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      req_valid = 1'b1;
      req_coin = c;
      do @(posedge clock); while (req_stall);
      predicted = sort_coin(c);
      coin_results_due.push_back(typed ? typed_result : predicted);
      @(negedge clock);
   endtask

   task automatic wait_for_results();
      req_valid = 1'b0;
      burst_left = 0;
      while (coin_results_due.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic set_register(ccrc_pkg::csr_index_type idx, logic [12:0] value);
      csr_write = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_write = 1'b0;
      case (idx)
         ccrc_pkg::CSR_BENT_LIMIT: bent_limit = value;
         ccrc_pkg::CSR_OTHER_LIMIT: other_limit = value;
         default: roll_cap[idx] = value[5:0];
      endcase
   endtask

   // receiver back-pressure: stretches of free flow, light and heavy stalling
   initial begin : stall_pattern
      int unsigned mode;
      int unsigned len;
      rsp_stall = 1'b0;
      forever begin
         mode = $urandom_range(0, 3);
         len = $urandom_range(8, 40);
         repeat (len) begin
            case (mode)
               0: rsp_stall = 1'b0;
               1: rsp_stall = ($urandom_range(0, 3) == 0);
               2: rsp_stall = 1'($urandom_range(0, 1));
               default: rsp_stall = ($urandom_range(0, 3) != 0);
            endcase
            @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin : result_check
      ccrc_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (coin_results_due.size() == 0) begin
            report_mismatch("unrequested beat, destination", 32'(rsp_destination), 32'd0);
         end else begin
            want = coin_results_due.pop_front();
            if (rsp_destination != want.destination)
               report_mismatch("destination", 32'(rsp_destination), 32'(want.destination));
            if (rsp_container_replaced != want.container_replaced)
               report_mismatch("container_replaced", 32'(rsp_container_replaced),
                               32'(want.container_replaced));
            if (rsp_fill_count != want.fill_count)
               report_mismatch("fill_count", 32'(rsp_fill_count), 32'(want.fill_count));
            if (rsp_container_weight != want.container_weight)
               report_mismatch("container_weight", 32'(rsp_container_weight),
                               32'(want.container_weight));
            if (rsp_full_units_made != want.full_units_made)
               report_mismatch("full_units_made", 32'(rsp_full_units_made),
                               32'(want.full_units_made));
            if (rsp_total_weight != want.total_weight)
               report_mismatch("total_weight", rsp_total_weight, want.total_weight);
            if (rsp_other_total_count != want.other_total_count)
               report_mismatch("other_total_count", rsp_other_total_count,
                               want.other_total_count);
         end
      end
   end

   initial begin : stimulus
      int cap;
      int lim;
      reset = 1'b1;
      req_valid = 1'b0;
      req_coin = '0;
      csr_write = 1'b0;
      csr_index = ccrc_pkg::CSR_NICKEL_CAP;
      csr_wdata = '0;
      roll_cap = ccrc_pkg::CAP_RESET;
      bent_limit = ccrc_pkg::BENT_LIMIT_RESET;
      other_limit = ccrc_pkg::OTHER_LIMIT_RESET;
      foreach (roll_count[k]) begin
         roll_count[k] = '0;
         rolls_done[k] = '0;
      end
      bent_raw = '0;
      other_raw = '0;
      other_coins = '0;
      other_bins_done = '0;
      other_coin_total = '0;
      bent_weight_sum = '0;
      other_weight_sum = '0;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      foreach (DIRECTED[r]) send_coin(DIRECTED[r].coin, DIRECTED[r].typed, DIRECTED[r].result);

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         wait_for_results();
         // capacity writes carry random upper bits, which the block must drop
         for (int k = 0; k < ccrc_pkg::NUM_ROLLS; k++) begin
            if (PH_CAP[phase] >= 0) cap = PH_CAP[phase];
            else if ($urandom_range(0, 3) == 0) cap = $urandom_range(0, 63);
            else cap = $urandom_range(0, 6);
            set_register(ccrc_pkg::csr_index_type'(k), {7'($urandom), 6'(cap)});
         end
         lim = PH_BENT_LIM[phase] >= 0 ? PH_BENT_LIM[phase] :
               ($urandom_range(0, 1) == 0 ? $urandom_range(0, 1500) : $urandom_range(0, 8191));
         set_register(ccrc_pkg::CSR_BENT_LIMIT, 13'(lim));
         lim = PH_OTHR_LIM[phase] >= 0 ? PH_OTHR_LIM[phase] :
               ($urandom_range(0, 1) == 0 ? $urandom_range(0, 1500) : $urandom_range(0, 8191));
         set_register(ccrc_pkg::CSR_OTHER_LIMIT, 13'(lim));
         for (int i = 0; i < PH_ITEMS[phase]; i++) begin
            // hold off mid-phase until the pipe is empty
            if (i == PH_ITEMS[phase] / 2) wait_for_results();
            send_coin(random_coin(PH_ROLL_PCT[phase], PH_BENT_PCT[phase], PH_HEAVY[phase]),
                      1'b0, NO_RESULT);
         end
      end
      wait_for_results();

      if (mismatch_count == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
